### src/bresenham_step_generator_core_assert.svh
// assertion macros shared by the step generator rtl
`ifndef BRESENHAM_STEP_GENERATOR_CORE_ASSERT_SVH
`define BRESENHAM_STEP_GENERATOR_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define BSG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// antecedent holds -> consequent holds in the next cycle
`define BSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/bsg_pkg.sv
// ----------------------------------------------------------------------------
// bsg_pkg
// Widths, codes and shared types of the Bresenham step generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsg_pkg;

  localparam int STEP_W    = 24;
  localparam int POS_W     = 32;
  localparam int CNT_W     = STEP_W + 2;
  localparam int EVT_W     = STEP_W + 1;
  localparam int OUT_POS_W = 32;
  localparam int N_LANES   = 4;
  localparam int N_ES      = 3;
  localparam int N_SW      = 2 * N_ES;

  // item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = N_SW;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDSTOP_EN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDSTOP_INV = 1'd1;

  // per-item control broadcast to every lane
  typedef struct packed {
    logic load;
    logic tick;
    logic clear;
    logic chk_en;
  } lane_ctrl_t;

  // what one lane found this item
  typedef struct packed {
    logic pulse;
    logic hit;
  } lane_stat_t;

  // one result item
  typedef struct packed {
    logic [N_LANES-1:0]                 step_pulses;
    logic [N_LANES-1:0]                 dir_out;
    logic                               move_done;
    logic                               busy_res;
    logic [N_ES-1:0]                    hit_flags;
    logic [N_LANES-1:0][OUT_POS_W-1:0]  pos;
    logic [N_ES-1:0][OUT_POS_W-1:0]     trig;
  } res_t;

endpackage

`default_nettype wire

### src/bsg_if.sv
// ----------------------------------------------------------------------------
// bsg_if
// Valid/ready channels for move items and step result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsg_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [bsg_pkg::STEP_W-1:0]   axis_steps_x;
  logic [bsg_pkg::STEP_W-1:0]   axis_steps_y;
  logic [bsg_pkg::STEP_W-1:0]   axis_steps_z;
  logic [bsg_pkg::STEP_W-1:0]   axis_steps_e;
  logic [bsg_pkg::STEP_W-1:0]   event_total;
  logic [bsg_pkg::N_LANES-1:0]  move_dirs;
  logic [bsg_pkg::N_SW-1:0]     switch_levels;

  modport source (output valid, func, axis_steps_x, axis_steps_y, axis_steps_z,
                  axis_steps_e, event_total, move_dirs, switch_levels,
                  input ready);
  modport sink   (input valid, func, axis_steps_x, axis_steps_y, axis_steps_z,
                  axis_steps_e, event_total, move_dirs, switch_levels,
                  output ready);
endinterface

interface bsg_out_if;
  logic                           valid;
  logic                           ready;
  logic [bsg_pkg::N_LANES-1:0]    step_pulses;
  logic [bsg_pkg::N_LANES-1:0]    dir_out;
  logic                           move_done;
  logic                           busy_res;
  logic [bsg_pkg::N_ES-1:0]       hit_flags;
  logic [bsg_pkg::OUT_POS_W-1:0]  pos_x;
  logic [bsg_pkg::OUT_POS_W-1:0]  pos_y;
  logic [bsg_pkg::OUT_POS_W-1:0]  pos_z;
  logic [bsg_pkg::OUT_POS_W-1:0]  pos_e;
  logic [bsg_pkg::OUT_POS_W-1:0]  trig_x;
  logic [bsg_pkg::OUT_POS_W-1:0]  trig_y;
  logic [bsg_pkg::OUT_POS_W-1:0]  trig_z;

  modport source (output valid, step_pulses, dir_out, move_done, busy_res, hit_flags,
                  pos_x, pos_y, pos_z, pos_e, trig_x, trig_y, trig_z,
                  input ready);
  modport sink   (input valid, step_pulses, dir_out, move_done, busy_res, hit_flags,
                  pos_x, pos_y, pos_z, pos_e, trig_x, trig_y, trig_z,
                  output ready);
endinterface

`default_nettype wire

### src/bsg_lane.sv
// ----------------------------------------------------------------------------
// bsg_lane
// One axis: error counter, step decision, position and endstop confirmation.
// ----------------------------------------------------------------------------
`default_nettype none

module bsg_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bsg_pkg::lane_ctrl_t         ctrl,
  input  logic [bsg_pkg::STEP_W-1:0]  steps_in,
  input  logic [bsg_pkg::STEP_W-1:0]  total,
  input  logic                        dir_bit,
  input  logic [1:0]                  sw_levels,
  input  logic [1:0]                  sw_invert,
  output bsg_pkg::lane_stat_t         stat,
  output logic [bsg_pkg::POS_W-1:0]   pos_nxt,
  output logic [bsg_pkg::POS_W-1:0]   trig_nxt,
  output logic                        hit_flag_nxt
);
  import bsg_pkg::*;

  logic [STEP_W-1:0] steps_r;
  logic [CNT_W-1:0]  err_r, err_nxt;
  logic [POS_W-1:0]  pos_r, trig_r;
  logic [1:0]        prev_r, prev_nxt;
  logic              hit_flag_r;

  logic [CNT_W-1:0]  err_sum;
  logic [CNT_W-1:0]  err_sub;
  logic [CNT_W-1:0]  half_neg;
  logic              step_ok;
  logic              sw_sel;
  logic              sw_lvl;
  logic              hit;

  // bresenham accumulate and step decision
  assign err_sum  = err_r + CNT_W'(steps_r);
  assign err_sub  = err_sum - CNT_W'(total);
  assign half_neg = CNT_W'(0) - CNT_W'(total >> 1);
  assign step_ok  = (err_sum != '0) && !err_sum[CNT_W-1];

  // endstop in the direction of travel: min when negative
  assign sw_sel = ~dir_bit;
  assign sw_lvl = sw_levels[sw_sel] ^ sw_invert[sw_sel];
  assign hit    = ctrl.tick && ctrl.chk_en && sw_lvl && prev_r[sw_sel] && (steps_r != '0);

  always_comb begin
    err_nxt  = err_r;
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    if (ctrl.load) begin
      err_nxt = half_neg;
    end else if (ctrl.tick) begin
      err_nxt = step_ok ? err_sub : err_sum;
      if (step_ok) begin
        pos_nxt = dir_bit ? pos_r - POS_W'(1) : pos_r + POS_W'(1);
      end
      if (ctrl.chk_en) begin
        prev_nxt[sw_sel] = sw_lvl;
      end
    end
  end

  assign trig_nxt     = hit ? pos_r : trig_r;
  assign hit_flag_nxt = ctrl.clear ? 1'b0 : (hit_flag_r | hit);

  assign stat.pulse = ctrl.tick && step_ok;
  assign stat.hit   = hit;

  // move step count, written on load
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      steps_r <= steps_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r      <= '0;
      pos_r      <= '0;
      trig_r     <= '0;
      prev_r     <= '0;
      hit_flag_r <= 1'b0;
    end else begin
      err_r      <= err_nxt;
      pos_r      <= pos_nxt;
      trig_r     <= trig_nxt;
      prev_r     <= prev_nxt;
      hit_flag_r <= hit_flag_nxt;
    end
  end

endmodule

`default_nettype wire

### src/bsg_merge.sv
// ----------------------------------------------------------------------------
// bsg_merge
// Combines lane findings into one result item and buffers it in two slots.
// ----------------------------------------------------------------------------
`default_nettype none

module bsg_merge (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                push,
  input  bsg_pkg::lane_stat_t [bsg_pkg::N_LANES-1:0]          stat,
  input  logic [bsg_pkg::N_LANES-1:0]                         dir_out,
  input  logic                                                move_done,
  input  logic                                                busy_res,
  input  logic [bsg_pkg::N_ES-1:0]                            hit_flags,
  input  logic [bsg_pkg::N_LANES-1:0][bsg_pkg::POS_W-1:0]     pos,
  input  logic [bsg_pkg::N_ES-1:0][bsg_pkg::POS_W-1:0]        trig,
  output logic                                                any_hit,
  output logic                                                push_ready,
  bsg_out_if.source                                           out_ch
);
  import bsg_pkg::*;

  res_t res;
  res_t main_r, skid_r;
  logic main_v_r, skid_v_r;
  logic pop;

  // any lane saw a confirmed endstop
  always_comb begin
    any_hit = 1'b0;
    for (int i = 0; i < N_LANES; i++) begin
      any_hit = any_hit | stat[i].hit;
    end
  end

  // gather pulses and positions across lanes
  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      res.step_pulses[i] = stat[i].pulse;
      res.pos[i]         = OUT_POS_W'(signed'(pos[i]));
    end
    for (int i = 0; i < N_ES; i++) begin
      res.trig[i] = OUT_POS_W'(signed'(trig[i]));
    end
    res.dir_out   = dir_out;
    res.move_done = move_done;
    res.busy_res  = busy_res;
    res.hit_flags = hit_flags;
  end

  assign pop        = main_v_r && out_ch.ready;
  assign push_ready = !skid_v_r;

  // output slot plus skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid       = main_v_r;
  assign out_ch.step_pulses = main_r.step_pulses;
  assign out_ch.dir_out     = main_r.dir_out;
  assign out_ch.move_done   = main_r.move_done;
  assign out_ch.busy_res    = main_r.busy_res;
  assign out_ch.hit_flags   = main_r.hit_flags;
  assign out_ch.pos_x       = main_r.pos[0];
  assign out_ch.pos_y       = main_r.pos[1];
  assign out_ch.pos_z       = main_r.pos[2];
  assign out_ch.pos_e       = main_r.pos[3];
  assign out_ch.trig_x      = main_r.trig[0];
  assign out_ch.trig_y      = main_r.trig[1];
  assign out_ch.trig_z      = main_r.trig[2];

endmodule

`default_nettype wire

### src/bresenham_step_generator_core.sv
// ----------------------------------------------------------------------------
// bresenham_step_generator_core
// Four-axis Bresenham step generator with endstop monitoring.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: a load (starts a move when idle),
//   a tick (one step event of the active move) or a clear of the hit flags.
//   out_ch returns exactly one result item per input item, in order: the
//   step pulses of that tick, direction, done/busy status, sticky hit flags
//   and the signed axis and trigger positions after the item.
//   cfg_we/cfg_idx/cfg_data write the endstop enable (index 0) and the
//   per-switch inversion bits (index 1); write only while the block is idle.
// Result path and throughput:
//   a result is registered in the result slot, or the skid slot if it is held;
//   one item per cycle is sustained while out_ch takes results, set by the
//   four axis lanes updating error counter, position and endstop check at once.
// Reset and stall:
//   rst_n (synchronous, active low) clears positions, counters, hit flags and
//   the move, and sets the enable and inversion registers to all ones.
//   A result slot and a skid slot sit at the output; with both full, in_ch
//   ready drops until out_ch takes an item, and nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_step_generator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  bsg_in_if.sink                          in_ch,
  bsg_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bsg_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bsg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bsg_pkg::*;

  `include "bresenham_step_generator_core_assert.svh"

  // configuration registers
  logic            chk_en_r;
  logic [N_SW-1:0] inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_en_r <= 1'b1;
      inv_r    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ENDSTOP_EN:  chk_en_r <= cfg_data[0];
        CFG_ENDSTOP_INV: inv_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // move control state
  logic               active_r, active_nxt;
  logic [N_LANES-1:0] dir_r, dir_nxt;
  logic [STEP_W-1:0]  total_r;
  logic [EVT_W-1:0]   events_r, events_nxt, events_inc;

  logic       accept, push_ready, any_hit, done;
  lane_ctrl_t ctrl;
  logic [STEP_W-1:0] total;

  lane_stat_t [N_LANES-1:0]            stat;
  logic [N_LANES-1:0][POS_W-1:0]       pos_nxt;
  logic [N_LANES-1:0][POS_W-1:0]       trig_nxt;
  logic [N_LANES-1:0]                  flag_nxt;
  logic [N_LANES-1:0][STEP_W-1:0]      steps_in;
  logic [N_LANES-1:0][1:0]             lane_lvl;
  logic [N_LANES-1:0][1:0]             lane_inv;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // item decode into lane control
  assign ctrl.load   = accept && (in_ch.func == FUNC_LOAD) && !active_r;
  assign ctrl.tick   = accept && (in_ch.func == FUNC_TICK) && active_r;
  assign ctrl.clear  = accept && (in_ch.func == FUNC_CLEAR);
  assign ctrl.chk_en = chk_en_r;

  assign total = ctrl.load ? in_ch.event_total : total_r;

  assign steps_in[0] = in_ch.axis_steps_x;
  assign steps_in[1] = in_ch.axis_steps_y;
  assign steps_in[2] = in_ch.axis_steps_z;
  assign steps_in[3] = in_ch.axis_steps_e;

  // switch pairs per axis; the extruder has none
  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      lane_lvl[i] = 2'b00;
      lane_inv[i] = 2'b00;
    end
    for (int i = 0; i < N_ES; i++) begin
      lane_lvl[i] = in_ch.switch_levels[2*i +: 2];
      lane_inv[i] = inv_r[2*i +: 2];
    end
  end

  // axis lanes
  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    bsg_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .steps_in     (steps_in[g]),
      .total        (total),
      .dir_bit      (dir_r[g]),
      .sw_levels    (lane_lvl[g]),
      .sw_invert    (lane_inv[g]),
      .stat         (stat[g]),
      .pos_nxt      (pos_nxt[g]),
      .trig_nxt     (trig_nxt[g]),
      .hit_flag_nxt (flag_nxt[g])
    );
  end

  // event count and end of move
  assign events_inc = events_r + EVT_W'(1);
  assign done       = ctrl.tick && (any_hit || (events_inc >= EVT_W'(total_r)));

  always_comb begin
    active_nxt = active_r;
    dir_nxt    = dir_r;
    events_nxt = events_r;
    if (ctrl.load) begin
      active_nxt = 1'b1;
      dir_nxt    = in_ch.move_dirs;
      events_nxt = '0;
    end else if (ctrl.tick) begin
      events_nxt = events_inc;
      if (done) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      dir_r    <= '0;
      events_r <= '0;
    end else begin
      active_r <= active_nxt;
      dir_r    <= dir_nxt;
      events_r <= events_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      total_r <= in_ch.event_total;
    end
  end

  // merge lanes into the result item
  bsg_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .stat       (stat),
    .dir_out    (dir_nxt),
    .move_done  (done),
    .busy_res   (active_nxt),
    .hit_flags  (flag_nxt[N_ES-1:0]),
    .pos        (pos_nxt),
    .trig       (trig_nxt[N_ES-1:0]),
    .any_hit    (any_hit),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

  // checks
  `BSG_ASSERT_NEXT(a_done_ends_move, clk, rst_n, done, !active_r)
  `BSG_ASSERT_NEXT(a_load_starts_move, clk, rst_n, ctrl.load, active_r && (events_r == '0))
  `BSG_ASSERT_SAME(a_stall_means_full, clk, rst_n, !in_ch.ready, out_ch.valid)
  `BSG_ASSERT_SAME(a_done_not_busy, clk, rst_n, out_ch.valid && out_ch.move_done,
                   !out_ch.busy_res)

endmodule

`default_nettype wire

### sim/bsg_status_checker.sv
// ----------------------------------------------------------------------------
// bsg_status_checker
// Watches the move and status channels and the register port of the step
// generator. Every accepted move item runs through a local model of the
// Bresenham lanes and endstop logic. The status item it yields waits in order
// until the block returns one, then it is compared field by field.
// ----------------------------------------------------------------------------

module bsg_status_checker
  import bsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bsg_in_if                     move_ch,
  bsg_out_if                    status_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);

  // register copies
  logic              chk_en;
  logic [N_SW-1:0]   sw_invert;

  // move and lane state
  logic              moving;
  logic [STEP_W-1:0] axis_steps [N_LANES];
  logic [STEP_W-1:0] events_total;
  logic [N_LANES-1:0] dir_reg;
  logic [CNT_W-1:0]  err_acc [N_LANES];
  logic [EVT_W-1:0]  events_run;
  logic [POS_W-1:0]  axis_pos [N_LANES];
  logic [POS_W-1:0]  trig_pos [N_ES];
  logic [N_SW-1:0]   sw_prev;
  logic [N_ES-1:0]   hit_latch;

  res_t              awaited_status [$];
  int                err_cnt;

  task automatic clear_state();
    int a;
    chk_en       = 1'b1;
    sw_invert    = '1;
    moving       = 1'b0;
    events_total = '0;
    dir_reg      = '0;
    events_run   = '0;
    sw_prev      = '0;
    hit_latch    = '0;
    for (a = 0; a < N_LANES; a++) begin
      axis_steps[a] = '0;
      err_acc[a]    = '0;
      axis_pos[a]   = '0;
    end
    for (a = 0; a < N_ES; a++) trig_pos[a] = '0;
  endtask

  // one item through the lanes, returns the status the block should report
  task automatic advance_stepper(output res_t st);
    logic [N_SW-1:0]  lvl;
    logic [CNT_W-1:0] acc;
    int               sw;
    int               a;
    st = '0;
    case (move_ch.func)
      FUNC_LOAD: begin
        if (!moving) begin
          axis_steps[0] = move_ch.axis_steps_x;
          axis_steps[1] = move_ch.axis_steps_y;
          axis_steps[2] = move_ch.axis_steps_z;
          axis_steps[3] = move_ch.axis_steps_e;
          events_total  = move_ch.event_total;
          dir_reg       = move_ch.move_dirs;
          for (a = 0; a < N_LANES; a++) err_acc[a] = -CNT_W'(events_total >> 1);
          events_run = '0;
          moving     = 1'b1;
        end
      end
      FUNC_CLEAR: hit_latch = '0;
      FUNC_TICK: begin
        if (moving) begin
          lvl = move_ch.switch_levels ^ sw_invert;
          // only the switch ahead of each axis is sampled, two in a row trip it
          if (chk_en) begin
            for (a = 0; a < N_ES; a++) begin
              sw = 2 * a + (dir_reg[a] ? 0 : 1);
              if (lvl[sw] && sw_prev[sw] && axis_steps[a] != '0) begin
                trig_pos[a]  = axis_pos[a];
                hit_latch[a] = 1'b1;
                events_run   = EVT_W'(events_total);
              end
              sw_prev[sw] = lvl[sw];
            end
          end
          // step event, the hit tick still steps
          for (a = 0; a < N_LANES; a++) begin
            acc = err_acc[a] + CNT_W'(axis_steps[a]);
            if (acc != '0 && !acc[CNT_W-1]) begin
              acc = acc - CNT_W'(events_total);
              axis_pos[a] = dir_reg[a] ? axis_pos[a] - 1'b1 : axis_pos[a] + 1'b1;
              st.step_pulses[a] = 1'b1;
            end
            err_acc[a] = acc;
          end
          events_run = events_run + 1'b1;
          if (events_run >= EVT_W'(events_total)) begin
            moving       = 1'b0;
            st.move_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    st.dir_out   = dir_reg;
    st.busy_res  = moving;
    st.hit_flags = hit_latch;
    for (a = 0; a < N_LANES; a++) st.pos[a] = OUT_POS_W'(signed'(axis_pos[a]));
    for (a = 0; a < N_ES; a++) st.trig[a] = OUT_POS_W'(signed'(trig_pos[a]));
  endtask

  task automatic note_field(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= 60)
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  task automatic compare_status(input res_t want);
    note_field("step_pulses", want.step_pulses, status_ch.step_pulses);
    note_field("dir_out", want.dir_out, status_ch.dir_out);
    note_field("move_done", want.move_done, status_ch.move_done);
    note_field("busy_res", want.busy_res, status_ch.busy_res);
    note_field("hit_flags", want.hit_flags, status_ch.hit_flags);
    note_field("pos_x", want.pos[0], status_ch.pos_x);
    note_field("pos_y", want.pos[1], status_ch.pos_y);
    note_field("pos_z", want.pos[2], status_ch.pos_z);
    note_field("pos_e", want.pos[3], status_ch.pos_e);
    note_field("trig_x", want.trig[0], status_ch.trig_x);
    note_field("trig_y", want.trig[1], status_ch.trig_y);
    note_field("trig_z", want.trig[2], status_ch.trig_z);
  endtask

  // register writes, result compare, then the new item
  always @(posedge clk) begin : monitor
    res_t st;
    if (!rst_n) begin
      clear_state();
      awaited_status.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ENDSTOP_EN:  chk_en = cfg_data[0];
          CFG_ENDSTOP_INV: sw_invert = cfg_data[N_SW-1:0];
          default: ;
        endcase
      end
      if (status_ch.valid && status_ch.ready) begin
        if (awaited_status.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 60)
            $display("%0t: status item expected none actual one", $time);
        end else begin
          compare_status(awaited_status.pop_front());
        end
      end
      if (move_ch.valid && move_ch.ready) begin
        advance_stepper(st);
        awaited_status.push_back(st);
      end
    end
    errors      <= err_cnt;
    outstanding <= awaited_status.size();
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives moves, ticks and flag clears into the step generator under random
// stalls on both channels, with a few register settings. The status checker
// next to the block predicts and compares every status item.
// ----------------------------------------------------------------------------

module testbench;
  import bsg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES    = 5;
  localparam int PHASE_ITEMS = 360;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_TICKS = 26;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]                      func;
    logic [N_LANES-1:0][STEP_W-1:0]  steps;
    logic [STEP_W-1:0]               total;
    logic [N_LANES-1:0]              dirs;
    logic [N_SW-1:0]                 levels;
  } move_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    cycle_cnt = 0;
  int                    accepted = 0;
  int                    errors;
  int                    outstanding;
  bit                    calm = 1'b0;
  logic                  en_now = 1'b1;
  logic [N_SW-1:0]       inv_now = '1;
  int                    send_cnt = 0;
  int                    send_mode = 0;

  bsg_in_if  move_ch ();
  bsg_out_if status_ch ();

  bresenham_step_generator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (move_ch),
    .out_ch   (status_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  bsg_status_checker status_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .move_ch     (move_ch),
    .status_ch   (status_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && move_ch.valid && move_ch.ready) accepted <= accepted + 1;
  end

  // run limit
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // result side: random stall bursts, one long hold-off to back up the block
  initial begin : result_sink
    int  stall;
    int  beats;
    int  mode;
    bit  held;
    held  = 1'b0;
    beats = 0;
    mode  = 0;
    status_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (beats % 200 == 0) mode = $urandom_range(0, 3);
      beats++;
      if (!held && accepted >= HOLD_AT) begin
        held = 1'b1;
        status_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!calm && mode != 0 && $urandom_range(0, 2 << mode) == 0) begin
        stall = $urandom_range(1, 18);
        status_ch.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        status_ch.ready <= 1'b1;
      end
    end
  end

  function automatic move_item_t junk_item(input logic [1:0] f);
    move_item_t it;
    it.func   = f;
    it.steps  = {$urandom, $urandom, $urandom};
    it.total  = STEP_W'($urandom);
    it.dirs   = N_LANES'($urandom);
    it.levels = N_SW'($urandom);
    return it;
  endfunction

  function automatic move_item_t tick_item(input logic [N_SW-1:0] lv);
    move_item_t it;
    it        = junk_item(FUNC_TICK);
    it.levels = lv;
    return it;
  endfunction

  function automatic move_item_t load_item(input logic [STEP_W-1:0] sx, sy, sz, se,
                                           input logic [STEP_W-1:0] tot,
                                           input logic [N_LANES-1:0] dirs);
    move_item_t it;
    it       = junk_item(FUNC_LOAD);
    it.steps = {se, sz, sy, sx};
    it.total = tot;
    it.dirs  = dirs;
    return it;
  endfunction

  // offer one item, at times after a random gap, until it is taken
  task automatic send(input move_item_t it);
    if (send_cnt % 150 == 0) send_mode = $urandom_range(0, 3);
    send_cnt++;
    if (!calm && send_mode != 0 && $urandom_range(0, 2 << send_mode) == 0) begin
      move_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    move_ch.valid         <= 1'b1;
    move_ch.func          <= it.func;
    move_ch.axis_steps_x  <= it.steps[0];
    move_ch.axis_steps_y  <= it.steps[1];
    move_ch.axis_steps_z  <= it.steps[2];
    move_ch.axis_steps_e  <= it.steps[3];
    move_ch.event_total   <= it.total;
    move_ch.move_dirs     <= it.dirs;
    move_ch.switch_levels <= it.levels;
    @(posedge clk);
    while (move_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // stop offering and wait for every status item to come back
  task automatic settle();
    move_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_regs(input logic en, input logic [N_SW-1:0] inv);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ENDSTOP_EN;
    cfg_data <= {(CFG_DATA_W-1)'($urandom), en};
    @(posedge clk);
    cfg_idx  <= CFG_ENDSTOP_INV;
    cfg_data <= inv;
    @(posedge clk);
    cfg_we   <= 1'b0;
    en_now   = en;
    inv_now  = inv;
  endtask

  // one move: a load, then about enough ticks to finish it, with noise mixed in
  task automatic random_move();
    move_item_t        it;
    logic [STEP_W-1:0] tot;
    logic [N_SW-1:0]   lv;
    int                n;
    int                i;
    int                a;
    int                mode;
    int                trip_at;
    // long move with full-width counts, ended by a confirmed endstop
    if (en_now && $urandom_range(0, 19) == 0) begin
      it = junk_item(FUNC_LOAD);
      if (it.steps[0] == '0) it.steps[0] = 1;
      send(it);
      repeat ($urandom_range(1, 6)) send(tick_item(inv_now));
      repeat (2) send(tick_item(~inv_now));
      return;
    end
    tot = ($urandom_range(0, 49) == 0) ? '0 : STEP_W'($urandom_range(1, 24));
    it = junk_item(FUNC_LOAD);
    it.total = tot;
    for (a = 0; a < N_LANES; a++) begin
      if ($urandom_range(0, 9) == 0) it.steps[a] = STEP_W'($urandom_range(0, 2 * tot + 3));
      else it.steps[a] = STEP_W'($urandom_range(0, tot));
    end
    send(it);
    n       = ((tot == 0) ? 1 : int'(tot)) + $urandom_range(0, 2);
    mode    = $urandom_range(0, 9);
    trip_at = $urandom_range(0, n);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 39))
        0: send(junk_item(FUNC_CLEAR));
        1: begin
          it = junk_item(FUNC_LOAD);
          it.total = STEP_W'($urandom_range(0, 24));
          send(it);
        end
        2: send(junk_item(FUNC_NONE));
        default: ;
      endcase
      // quiet switches mostly, sometimes noisy, sometimes held active
      if (mode == 9 && i >= trip_at) lv = ~inv_now;
      else if (mode >= 7 || $urandom_range(0, 19) == 0) lv = N_SW'($urandom);
      else lv = inv_now;
      send(tick_item(lv));
    end
  endtask

  initial begin : stimulus
    int ph;
    int target;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= CFG_ENDSTOP_EN;
    cfg_data              <= '0;
    move_ch.valid         <= 1'b0;
    move_ch.func          <= FUNC_TICK;
    move_ch.axis_steps_x  <= '0;
    move_ch.axis_steps_y  <= '0;
    move_ch.axis_steps_z  <= '0;
    move_ch.axis_steps_e  <= '0;
    move_ch.event_total   <= '0;
    move_ch.move_dirs     <= '0;
    move_ch.switch_levels <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items under the reset register values
    send(tick_item(inv_now));                        // tick with no move
    send(junk_item(FUNC_CLEAR));
    send(junk_item(FUNC_NONE));
    send(load_item(1, 0, 2, 0, 0, 4'b0000));         // zero event count
    send(tick_item(inv_now));
    send(load_item(5, 3, 0, 7, 5, 4'b1010));         // e count above event count
    send(load_item('1, '1, '1, '1, '1, 4'hf));       // ignored while busy
    repeat (5) send(tick_item(inv_now));
    send(load_item(0, 4, 0, 0, 4, 4'b0000));         // only y can trip
    repeat (2) send(tick_item(~inv_now));
    send(load_item('1, '1, '1, '1, '1, 4'hf));       // full counts, negative
    repeat (2) send(tick_item(~inv_now));            // x, y and z trip together
    send(junk_item(FUNC_CLEAR));

    // random phases, each under its own register setting
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0:       program_regs(1'b1, '0);
        1:       program_regs(1'b0, '1);
        2:       program_regs(1'b1, N_SW'($urandom));
        3:       program_regs(1'b0, N_SW'($urandom));
        default: program_regs(1'b1, '1);
      endcase
      calm   = (ph == N_PHASES - 1);
      target = accepted + PHASE_ITEMS;
      while (accepted < target) random_move();
      // finish any short move left running
      repeat (DRAIN_TICKS) send(tick_item(inv_now));
    end

    settle();
    repeat (4) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
